/* rtl/vna_pkg.sv */
// vna_pkg: shared types and constants for the vertex normal accumulator
// request and status codes, sequencer states, default sizes; no dependencies
`default_nettype none
package vna_pkg;

    localparam int MAX_VERTICES_DEF = 1024;
    localparam int SUM_WIDTH_DEF    = 48;

    localparam int IDX_W   = 11;
    localparam int COORD_W = 16;
    localparam int NORM_W  = 16;

    localparam logic [1:0] REQ_LOAD   = 2'd0;
    localparam logic [1:0] REQ_TRI    = 2'd1;
    localparam logic [1:0] REQ_READ   = 2'd2;
    localparam logic [1:0] REQ_UNUSED = 2'd3;

    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_RANGE = 2'd1;
    localparam logic [1:0] STAT_FULL  = 2'd2;

    localparam logic [NORM_W-1:0] ONE_Q14 = 16'd16384;

    typedef enum logic [3:0] {
        S_IDLE,
        S_TRI_RD,
        S_TRI_MUL,
        S_TRI_RMW,
        S_RD_MAG,
        S_RD_NORM,
        S_RD_SQ,
        S_RD_SQRT,
        S_RD_DIV,
        S_OUT
    } t_state;

endpackage
`default_nettype wire

/* rtl/vertex_normal_accumulator.sv */
// vertex_normal_accumulator: vertex table, per-vertex normal sums, normalized read
// uses vna_pkg; one shared 25x25 multiplier and a bit-serial root/divide step
//
//   channel  dir  tdata                                      tuser
//   s        in   coord_x, coord_y, coord_z, corner_a/b/c    req_type
//   m        out  normal_x, normal_y, normal_z               status
//
// load vertex, bad index, full table or unused request: straight from idle to the output state
// add triangle: 3 vertex reads, 6 products on the multiplier, 3 read-modify-writes
//   of the sum memory
// read normal: the one-bit-per-cycle normalize shift, the 25-step root and three
//   divides; a zero sum skips the root and the divides
// reset clears the vertex count and the handshake state; no clearing pass
// o_s_tready is high only while idle; a stalled result holds in the output register
`default_nettype none
module vertex_normal_accumulator #(
    parameter int MAX_VERTICES = vna_pkg::MAX_VERTICES_DEF,
    parameter int SUM_WIDTH    = vna_pkg::SUM_WIDTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [87:0] i_s_tdata,   // coord_x, coord_y, coord_z, corner_a, corner_b, corner_c
    input  logic [1:0]  i_s_tuser,   // req_type
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [47:0] o_m_tdata,   // normal_x, normal_y, normal_z
    output logic [1:0]  o_m_tuser    // status
);

    localparam int AW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
    localparam int CW = $clog2(MAX_VERTICES + 1);
    localparam int W  = SUM_WIDTH;
    localparam int W1 = SUM_WIDTH + 1;
    localparam int SW = 3 * SUM_WIDTH;
    localparam logic [W-1:0] LO_LIM = W'(1) << 23;
    localparam logic [W-1:0] HI_LIM = W'(1) << 24;

    vna_pkg::t_state r_state, n_state;

    logic [CW-1:0]  r_count;
    logic [4:0]     r_cnt;
    logic [1:0]     r_j;
    logic [AW-1:0]  r_adr [3];
    logic signed [15:0] r_vx [3];
    logic signed [15:0] r_vy [3];
    logic signed [15:0] r_vz [3];
    logic signed [49:0] r_prod;
    logic signed [34:0] r_acc [3];
    logic [W-1:0]   r_m [3];
    logic [2:0]     r_neg;
    logic [49:0]    r_sq;
    logic [27:0]    r_rem;
    logic [24:0]    r_root;
    logic [15:0]    r_numlo;
    logic [15:0]    r_q;
    logic [15:0]    r_res [3];
    logic [1:0]     r_status;
    logic           r_ovalid;
    logic [47:0]    r_odata;
    logic [1:0]     r_ouser;

    // memories
    logic [47:0]    vmem [MAX_VERTICES];
    logic [SW-1:0]  smem [MAX_VERTICES];
    logic [47:0]    r_vrd;
    logic [SW-1:0]  r_srd;
    logic           v_we, s_we;
    logic [AW-1:0]  v_wa, v_ra, s_wa, s_ra;
    logic [SW-1:0]  s_wd;

    // input fields
    logic [1:0]      in_req;
    logic [10:0]     in_a, in_b, in_c;
    logic            a_ok, b_ok, c_ok, full;
    logic [AW-1:0]   a_adr, b_adr, c_adr;

    logic signed [16:0] e1x, e1y, e1z, e2x, e2y, e2z;
    logic signed [24:0] mul_a, mul_b;
    logic [W-1:0]    mx, m_sel;
    logic [AW-1:0]   cur_adr;
    logic [1:0]      sel;
    logic [SW-1:0]   sat_wd;
    logic [25:0]     dv_t;
    logic            dv_ge;
    logic [27:0]     sq_t, sq_trial;
    logic [38:0]     dv_num;

    assign in_req = i_s_tuser;
    assign in_a   = i_s_tdata[58:48];
    assign in_b   = i_s_tdata[69:59];
    assign in_c   = i_s_tdata[80:70];
    assign a_ok   = (in_a != '0) && (32'(in_a) <= 32'(r_count));
    assign b_ok   = (in_b != '0) && (32'(in_b) <= 32'(r_count));
    assign c_ok   = (in_c != '0) && (32'(in_c) <= 32'(r_count));
    assign full   = (32'(r_count) == 32'(MAX_VERTICES));
    assign a_adr  = AW'(32'(in_a) - 32'd1);
    assign b_adr  = AW'(32'(in_b) - 32'd1);
    assign c_adr  = AW'(32'(in_c) - 32'd1);

    assign e1x = 17'(r_vx[0]) - 17'(r_vx[1]);
    assign e1y = 17'(r_vy[0]) - 17'(r_vy[1]);
    assign e1z = 17'(r_vz[0]) - 17'(r_vz[1]);
    assign e2x = 17'(r_vx[1]) - 17'(r_vx[2]);
    assign e2y = 17'(r_vy[1]) - 17'(r_vy[2]);
    assign e2z = 17'(r_vz[1]) - 17'(r_vz[2]);

    assign o_s_tready = (r_state == vna_pkg::S_IDLE);
    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = r_odata;
    assign o_m_tuser  = r_ouser;

    always_ff @(posedge i_clk) begin
        if (v_we) begin
            vmem[v_wa] <= i_s_tdata[47:0];
        end
        r_vrd <= vmem[v_ra];
    end

    always_ff @(posedge i_clk) begin
        if (s_we) begin
            smem[s_wa] <= s_wd;
        end
        r_srd <= smem[s_ra];
    end

    // corner and magnitude selection
    always_comb begin
        sel = (r_state == vna_pkg::S_TRI_RD) ? r_cnt[1:0] : r_cnt[2:1];
        case (sel)
            2'd0:    cur_adr = r_adr[0];
            2'd1:    cur_adr = r_adr[1];
            default: cur_adr = r_adr[2];
        endcase
        case (r_cnt[1:0])
            2'd0:    m_sel = r_m[0];
            2'd1:    m_sel = r_m[1];
            default: m_sel = r_m[2];
        endcase
        mx = r_m[0];
        if (r_m[1] > mx) begin
            mx = r_m[1];
        end
        if (r_m[2] > mx) begin
            mx = r_m[2];
        end
    end

    // saturating add of the face normal to the stored sums
    always_comb begin
        logic signed [W1-1:0] sm;
        for (int i = 0; i < 3; i++) begin
            sm = W1'($signed(r_srd[i*W +: W])) + W1'(r_acc[i]);
            if (sm[W] != sm[W-1]) begin
                sat_wd[i*W +: W] = sm[W] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
            end else begin
                sat_wd[i*W +: W] = sm[W-1:0];
            end
        end
    end

    // shared multiplier operands
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        if (r_state == vna_pkg::S_TRI_MUL) begin
            case (r_cnt)
                5'd0:    begin mul_a = 25'(e1y); mul_b = 25'(e2z); end
                5'd1:    begin mul_a = 25'(e1z); mul_b = 25'(e2y); end
                5'd2:    begin mul_a = 25'(e1z); mul_b = 25'(e2x); end
                5'd3:    begin mul_a = 25'(e1x); mul_b = 25'(e2z); end
                5'd4:    begin mul_a = 25'(e1x); mul_b = 25'(e2y); end
                5'd5:    begin mul_a = 25'(e1y); mul_b = 25'(e2x); end
                default: begin mul_a = '0; mul_b = '0; end
            endcase
        end else if (r_state == vna_pkg::S_RD_SQ) begin
            mul_a = {1'b0, m_sel[23:0]};
            mul_b = {1'b0, m_sel[23:0]};
        end
    end

    // root and divide steps
    always_comb begin
        sq_t     = {r_rem[25:0], r_sq[49:48]};
        sq_trial = {1'b0, r_root, 2'b01};
        dv_num   = {r_m[r_j][23:0], 14'b0} + 39'(r_root >> 1);
        dv_t     = {r_rem[24:0], r_numlo[15]};
        dv_ge    = (dv_t >= 26'(r_root));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= vna_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        v_we    = 1'b0;
        v_wa    = AW'(r_count);
        v_ra    = cur_adr;
        s_we    = 1'b0;
        s_wa    = cur_adr;
        s_wd    = sat_wd;
        s_ra    = cur_adr;
        case (r_state)
            vna_pkg::S_IDLE: begin
                if (i_s_tvalid) begin
                    n_state = vna_pkg::S_OUT;
                    case (in_req)
                        vna_pkg::REQ_LOAD: begin
                            if (!full) begin
                                v_we = 1'b1;
                                s_we = 1'b1;
                                s_wa = AW'(r_count);
                                s_wd = '0;
                            end
                        end
                        vna_pkg::REQ_TRI: begin
                            if (a_ok && b_ok && c_ok) begin
                                n_state = vna_pkg::S_TRI_RD;
                            end
                        end
                        vna_pkg::REQ_READ: begin
                            s_ra = a_adr;
                            if (a_ok) begin
                                n_state = vna_pkg::S_RD_MAG;
                            end
                        end
                        default: n_state = vna_pkg::S_OUT;
                    endcase
                end
            end
            vna_pkg::S_TRI_RD: begin
                if (r_cnt == 5'd3) begin
                    n_state = vna_pkg::S_TRI_MUL;
                end
            end
            vna_pkg::S_TRI_MUL: begin
                if (r_cnt == 5'd6) begin
                    n_state = vna_pkg::S_TRI_RMW;
                end
            end
            vna_pkg::S_TRI_RMW: begin
                // even cycle reads the sums, odd cycle writes them back
                s_we = r_cnt[0];
                if (r_cnt == 5'd5) begin
                    n_state = vna_pkg::S_OUT;
                end
            end
            vna_pkg::S_RD_MAG: n_state = vna_pkg::S_RD_NORM;
            vna_pkg::S_RD_NORM: begin
                if (mx == '0) begin
                    n_state = vna_pkg::S_OUT;
                end else if (mx >= LO_LIM && mx < HI_LIM) begin
                    n_state = vna_pkg::S_RD_SQ;
                end
            end
            vna_pkg::S_RD_SQ: begin
                if (r_cnt == 5'd3) begin
                    n_state = vna_pkg::S_RD_SQRT;
                end
            end
            vna_pkg::S_RD_SQRT: begin
                if (r_cnt == 5'd24) begin
                    n_state = vna_pkg::S_RD_DIV;
                end
            end
            vna_pkg::S_RD_DIV: begin
                if (r_cnt == 5'd16 && r_j == 2'd2) begin
                    n_state = vna_pkg::S_OUT;
                end
            end
            vna_pkg::S_OUT: begin
                if (!r_ovalid || i_m_tready) begin
                    n_state = vna_pkg::S_IDLE;
                end
            end
            default: n_state = vna_pkg::S_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (r_state == vna_pkg::S_IDLE && i_s_tvalid && in_req == vna_pkg::REQ_LOAD
                    && !full) begin
                r_count <= r_count + CW'(1);
            end
            if (r_state == vna_pkg::S_OUT && (!r_ovalid || i_m_tready)) begin
                r_ovalid <= 1'b1;
            end else if (i_m_tready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        logic [15:0] qn;
        qn = {r_q[14:0], dv_ge};
        if (qn > vna_pkg::ONE_Q14) begin
            qn = vna_pkg::ONE_Q14;
        end

        r_prod <= mul_a * mul_b;
        // each divide restarts the step count
        r_cnt  <= (n_state != r_state || (r_state == vna_pkg::S_RD_DIV && r_cnt == 5'd16))
                  ? 5'd0 : r_cnt + 5'd1;

        case (r_state)
            vna_pkg::S_IDLE: begin
                r_res[0] <= '0;
                r_res[1] <= '0;
                r_res[2] <= '0;
                r_adr[0] <= a_adr;
                r_adr[1] <= b_adr;
                r_adr[2] <= c_adr;
                if (in_req == vna_pkg::REQ_LOAD && full) begin
                    r_status <= vna_pkg::STAT_FULL;
                end else if (in_req == vna_pkg::REQ_TRI && !(a_ok && b_ok && c_ok)) begin
                    r_status <= vna_pkg::STAT_RANGE;
                end else if (in_req == vna_pkg::REQ_READ && !a_ok) begin
                    r_status <= vna_pkg::STAT_RANGE;
                end else begin
                    r_status <= vna_pkg::STAT_OK;
                end
            end
            vna_pkg::S_TRI_RD: begin
                case (r_cnt[1:0])
                    2'd1: begin
                        r_vx[0] <= r_vrd[15:0]; r_vy[0] <= r_vrd[31:16]; r_vz[0] <= r_vrd[47:32];
                    end
                    2'd2: begin
                        r_vx[1] <= r_vrd[15:0]; r_vy[1] <= r_vrd[31:16]; r_vz[1] <= r_vrd[47:32];
                    end
                    2'd3: begin
                        r_vx[2] <= r_vrd[15:0]; r_vy[2] <= r_vrd[31:16]; r_vz[2] <= r_vrd[47:32];
                    end
                    default: ;
                endcase
            end
            vna_pkg::S_TRI_MUL: begin
                // product k lands in the next cycle: even ones start a sum, odd ones subtract
                case (r_cnt)
                    5'd1:    r_acc[0] <= 35'(r_prod);
                    5'd2:    r_acc[0] <= r_acc[0] - 35'(r_prod);
                    5'd3:    r_acc[1] <= 35'(r_prod);
                    5'd4:    r_acc[1] <= r_acc[1] - 35'(r_prod);
                    5'd5:    r_acc[2] <= 35'(r_prod);
                    5'd6:    r_acc[2] <= r_acc[2] - 35'(r_prod);
                    default: ;
                endcase
            end
            vna_pkg::S_RD_MAG: begin
                for (int i = 0; i < 3; i++) begin
                    r_neg[i] <= r_srd[i*W + W - 1];
                    r_m[i]   <= r_srd[i*W + W - 1] ? W'(-r_srd[i*W +: W]) : r_srd[i*W +: W];
                end
            end
            vna_pkg::S_RD_NORM: begin
                for (int i = 0; i < 3; i++) begin
                    if (mx < LO_LIM) begin
                        r_m[i] <= r_m[i] << 1;
                    end else if (mx >= HI_LIM) begin
                        r_m[i] <= r_m[i] >> 1;
                    end
                end
            end
            vna_pkg::S_RD_SQ: begin
                if (r_cnt == 5'd1) begin
                    r_sq <= 50'(r_prod);
                end else if (r_cnt != 5'd0) begin
                    r_sq <= r_sq + 50'(r_prod);
                end
                r_rem  <= '0;
                r_root <= '0;
            end
            vna_pkg::S_RD_SQRT: begin
                // two radicand bits per step
                r_sq <= r_sq << 2;
                if (sq_t >= sq_trial) begin
                    r_rem  <= sq_t - sq_trial;
                    r_root <= {r_root[23:0], 1'b1};
                end else begin
                    r_rem  <= sq_t;
                    r_root <= {r_root[23:0], 1'b0};
                end
                r_j <= 2'd0;
            end
            vna_pkg::S_RD_DIV: begin
                if (r_cnt == 5'd0) begin
                    r_rem   <= 28'(dv_num[38:16]);
                    r_numlo <= dv_num[15:0];
                    r_q     <= '0;
                end else begin
                    r_rem   <= dv_ge ? 28'(dv_t - 26'(r_root)) : 28'(dv_t);
                    r_numlo <= {r_numlo[14:0], 1'b0};
                    r_q     <= {r_q[14:0], dv_ge};
                end
                if (r_cnt == 5'd16) begin
                    r_j        <= r_j + 2'd1;
                    r_res[r_j] <= r_neg[r_j] ? 16'(-qn) : qn;
                end
            end
            vna_pkg::S_OUT: begin
                if (!r_ovalid || i_m_tready) begin
                    r_odata <= {r_res[2], r_res[1], r_res[0]};
                    r_ouser <= r_status;
                end
            end
            default: ;
        endcase
    end

endmodule
`default_nettype wire

/* rtl/vna_checker.sv */
// vna_checker: port-level checks on the vertex normal accumulator
// uses vna_pkg; bound to the top level at the end of this file
`default_nettype none
module vna_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_tvalid,
    input logic        o_s_tready,
    input logic [87:0] i_s_tdata,
    input logic [1:0]  i_s_tuser,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [47:0] o_m_tdata,
    input logic [1:0]  o_m_tuser
);

    logic unused_in;
    assign unused_in = ^{i_s_tdata, i_s_tuser};

    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid)
        else $error("result word dropped while stalled");

    a_hold_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> $stable(o_m_tdata) && $stable(o_m_tuser))
        else $error("stalled result word changed");

    // one word in flight: the block takes nothing right after a word
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready |=> !o_s_tready)
        else $error("ready right after accepting a word");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser != vna_pkg::STAT_OK |-> o_m_tdata == 48'd0)
        else $error("error result carries a nonzero normal");

endmodule

bind vertex_normal_accumulator vna_checker u_vna_checker (.*);
`default_nettype wire

/* tb/sv/vertex_normal_accumulator_tb.sv */
// vertex_normal_accumulator_tb: self-checking bench for the vertex normal accumulator
// depends on vna_pkg and the vertex_normal_accumulator rtl; a tracker class predicts
// every result word from its own copy of the vertex table and normal sums
module vertex_normal_accumulator_tb;

    localparam int NVERT = vna_pkg::MAX_VERTICES_DEF;
    localparam longint SUM_MAX = (64'sd1 <<< (vna_pkg::SUM_WIDTH_DEF - 1)) - 1;
    localparam longint SUM_MIN = -SUM_MAX - 1;

    typedef struct packed {
        logic [15:0] nx;
        logic [15:0] ny;
        logic [15:0] nz;
        logic [1:0]  st;
    } t_normal_word;

    class vertex_normal_tracker;
        shortint vx[NVERT], vy[NVERT], vz[NVERT];
        longint  sum_x[NVERT], sum_y[NVERT], sum_z[NVERT];
        int      count;
        int      errors;
        t_normal_word pending_normals[$];

        function new();
            count  = 0;
            errors = 0;
        endfunction

        function bit idx_ok(int idx);
            return idx >= 1 && idx <= count;
        endfunction

        function longint sat_add(longint acc, longint inc);
            if (inc > 0 && acc > SUM_MAX - inc) return SUM_MAX;
            if (inc < 0 && acc < SUM_MIN - inc) return SUM_MIN;
            return acc + inc;
        endfunction

        function longint unsigned int_root(longint unsigned x);
            longint unsigned res, b;
            res = 0;
            b = 64'd1 << 62;
            while (b > x) b >>= 2;
            while (b != 0) begin
                if (x >= res + b) begin
                    x -= res + b;
                    res = (res >> 1) + b;
                end else begin
                    res >>= 1;
                end
                b >>= 2;
            end
            return res;
        endfunction

        function void note_request(logic [1:0] req, logic [87:0] d);
            t_normal_word w;
            int a, b, c, k, i;
            longint e1x, e1y, e1z, e2x, e2y, e2z, nx, ny, nz;
            longint s[3];
            longint unsigned m[3], mx, len, q;
            longint r[3];
            int corner[3];
            a = int'(d[58:48]);
            b = int'(d[69:59]);
            c = int'(d[80:70]);
            r = '{0, 0, 0};
            w.st = vna_pkg::STAT_OK;
            if (req == vna_pkg::REQ_LOAD) begin
                if (count >= NVERT) begin
                    w.st = vna_pkg::STAT_FULL;
                end else begin
                    vx[count] = d[15:0];
                    vy[count] = d[31:16];
                    vz[count] = d[47:32];
                    sum_x[count] = 0;
                    sum_y[count] = 0;
                    sum_z[count] = 0;
                    count++;
                end
            end else if (req == vna_pkg::REQ_TRI) begin
                if (!idx_ok(a) || !idx_ok(b) || !idx_ok(c)) begin
                    w.st = vna_pkg::STAT_RANGE;
                end else begin
                    a--; b--; c--;
                    e1x = longint'(vx[a]) - vx[b];
                    e1y = longint'(vy[a]) - vy[b];
                    e1z = longint'(vz[a]) - vz[b];
                    e2x = longint'(vx[b]) - vx[c];
                    e2y = longint'(vy[b]) - vy[c];
                    e2z = longint'(vz[b]) - vz[c];
                    nx = e1y * e2z - e1z * e2y;
                    ny = e1z * e2x - e1x * e2z;
                    nz = e1x * e2y - e1y * e2x;
                    corner = '{a, b, c};
                    for (i = 0; i < 3; i++) begin
                        k = corner[i];
                        sum_x[k] = sat_add(sum_x[k], nx);
                        sum_y[k] = sat_add(sum_y[k], ny);
                        sum_z[k] = sat_add(sum_z[k], nz);
                    end
                end
            end else if (req == vna_pkg::REQ_READ) begin
                if (!idx_ok(a)) begin
                    w.st = vna_pkg::STAT_RANGE;
                end else begin
                    k = a - 1;
                    s = '{sum_x[k], sum_y[k], sum_z[k]};
                    for (i = 0; i < 3; i++) m[i] = s[i] < 0 ? -s[i] : s[i];
                    mx = m[0];
                    if (m[1] > mx) mx = m[1];
                    if (m[2] > mx) mx = m[2];
                    if (mx != 0) begin
                        // bring the largest magnitude into [2^23, 2^24)
                        while (mx < (64'd1 << 23)) begin
                            mx <<= 1;
                            for (i = 0; i < 3; i++) m[i] <<= 1;
                        end
                        while (mx >= (64'd1 << 24)) begin
                            mx >>= 1;
                            for (i = 0; i < 3; i++) m[i] >>= 1;
                        end
                        len = int_root(m[0] * m[0] + m[1] * m[1] + m[2] * m[2]);
                        for (i = 0; i < 3; i++) begin
                            q = (m[i] * 16384 + len / 2) / len;
                            if (q > 16384) q = 16384;
                            r[i] = s[i] < 0 ? -longint'(q) : longint'(q);
                        end
                    end
                end
            end
            w.nx = r[0][15:0];
            w.ny = r[1][15:0];
            w.nz = r[2][15:0];
            pending_normals = {pending_normals, w};
        endfunction

        function void check_normal(logic [47:0] d, logic [1:0] st);
            t_normal_word w;
            if (pending_normals.size() == 0) begin
                $error("result word with nothing pending: data %h status %0d", d, st);
                errors++;
                return;
            end
            w = pending_normals.pop_front();
            if (d[15:0] !== w.nx) begin
                $error("normal_x: expected %0d actual %0d", $signed(w.nx), $signed(d[15:0]));
                errors++;
            end
            if (d[31:16] !== w.ny) begin
                $error("normal_y: expected %0d actual %0d", $signed(w.ny), $signed(d[31:16]));
                errors++;
            end
            if (d[47:32] !== w.nz) begin
                $error("normal_z: expected %0d actual %0d", $signed(w.nz), $signed(d[47:32]));
                errors++;
            end
            if (st !== w.st) begin
                $error("status: expected %0d actual %0d", w.st, st);
                errors++;
            end
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [87:0] s_tdata = '0;   // coord_x, coord_y, coord_z, corner_a, corner_b, corner_c
    logic [1:0]  s_tuser = '0;   // req_type
    logic        o_m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] o_m_tdata;      // normal_x, normal_y, normal_z
    logic [1:0]  o_m_tuser;      // status

    vertex_normal_tracker tracker = new();
    bit quiet = 1'b0;        // no idling on either side
    bit hold_start = 1'b0;
    int hold_left = 0;

    vertex_normal_accumulator DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // receiver: random backpressure plus a single long hold-off
    always @(negedge i_clk) begin
        if (hold_start) begin
            hold_start = 1'b0;
            hold_left = 400;
        end
        if (hold_left > 0) begin
            m_tready = 1'b0;
            hold_left--;
        end else if (quiet) begin
            m_tready = 1'b1;
        end else begin
            m_tready = $urandom_range(99) >= 15;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && m_tready)
            tracker.check_normal(o_m_tdata, o_m_tuser);
    end

    task automatic send_word(logic [1:0] req, logic [15:0] x, logic [15:0] y,
                             logic [15:0] z, logic [10:0] a, logic [10:0] b,
                             logic [10:0] c);
        while (!quiet && $urandom_range(99) < 15) begin
            s_tvalid = 1'b0;
            @(negedge i_clk);
        end
        s_tdata  = {7'd0, c, b, a, z, y, x};
        s_tuser  = req;
        s_tvalid = 1'b1;
        do @(posedge i_clk); while (!o_s_tready);
        tracker.note_request(req, s_tdata);
        @(negedge i_clk);
    endtask

    task automatic load_vertex(logic [15:0] x, logic [15:0] y, logic [15:0] z);
        send_word(vna_pkg::REQ_LOAD, x, y, z, 11'($urandom), 11'($urandom), 11'($urandom));
    endtask

    task automatic add_tri(logic [10:0] a, logic [10:0] b, logic [10:0] c);
        send_word(vna_pkg::REQ_TRI, 16'($urandom), 16'($urandom), 16'($urandom), a, b, c);
    endtask

    task automatic read_normal(logic [10:0] a);
        send_word(vna_pkg::REQ_READ, 16'($urandom), 16'($urandom), 16'($urandom), a,
                  11'($urandom), 11'($urandom));
    endtask

    task automatic wait_drained();
        s_tvalid = 1'b0;
        while (tracker.pending_normals.size() != 0) @(posedge i_clk);
        repeat (20) @(negedge i_clk);
    endtask

    function automatic logic [10:0] good_idx();
        return 11'($urandom_range(tracker.count, 1));
    endfunction

    function automatic logic [10:0] bad_idx();
        return ($urandom_range(1) == 0) ? 11'd0
                                         : 11'($urandom_range(2047, tracker.count + 1));
    endfunction

    initial begin
        #50_000_000;
        $display("vertex_normal_accumulator verification failed");
        $finish;
    end

    initial begin
        int n, kind;
        repeat (3) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // directed: empty table, unused request, extremes
        send_word(vna_pkg::REQ_UNUSED, 16'hffff, 16'hffff, 16'hffff, 11'h7ff, 11'h7ff, 11'h7ff);
        read_normal(11'd1);
        add_tri(11'd1, 11'd1, 11'd1);
        load_vertex(16'h7fff, 16'h7fff, 16'h7fff);
        load_vertex(16'h8000, 16'h7fff, 16'h7fff);
        load_vertex(16'h8000, 16'h8000, 16'h8000);
        load_vertex(16'h0000, 16'h0000, 16'h0000);
        load_vertex(16'($urandom), 16'($urandom), 16'($urandom));
        read_normal(11'd4);                 // zero-length sum
        add_tri(11'd1, 11'd2, 11'd3);
        add_tri(11'd4, 11'd5, 11'd2);
        add_tri(11'd5, 11'd5, 11'd4);       // repeated corners
        add_tri(11'd0, 11'd1, 11'd2);
        add_tri(11'd1, 11'd6, 11'd2);
        add_tri(11'd1, 11'd2, 11'h7ff);
        read_normal(11'd0);
        read_normal(11'd6);
        read_normal(11'h7ff);
        read_normal(11'd1);
        read_normal(11'd2);
        read_normal(11'd5);
        send_word(vna_pkg::REQ_UNUSED, 16'h0, 16'h0, 16'h0, 11'd0, 11'd0, 11'd0);

        // grow the sums on corners 1..3 far past the normalize window
        quiet = 1'b1;
        repeat (40) add_tri(11'd1, 11'd2, 11'd3);
        read_normal(11'd1);
        read_normal(11'd3);
        quiet = 1'b0;
        wait_drained();

        for (n = 0; n < 1300; n++) begin
            if (n == 400) hold_start = 1'b1;
            if (n == 600) quiet = 1'b1;
            if (n == 800) quiet = 1'b0;
            if (n == 1000) wait_drained();
            kind = $urandom_range(99);
            if (kind < 30) begin
                load_vertex(16'($urandom), 16'($urandom), 16'($urandom));
            end else if (kind < 64) begin
                add_tri(good_idx(), good_idx(), good_idx());
            end else if (kind < 70) begin
                case ($urandom_range(2))
                    0: add_tri(bad_idx(), good_idx(), good_idx());
                    1: add_tri(good_idx(), bad_idx(), good_idx());
                    default: add_tri(good_idx(), good_idx(), bad_idx());
                endcase
            end else if (kind < 92) begin
                read_normal(good_idx());
            end else if (kind < 97) begin
                read_normal(bad_idx());
            end else begin
                send_word(vna_pkg::REQ_UNUSED, 16'($urandom), 16'($urandom), 16'($urandom),
                          11'($urandom), 11'($urandom), 11'($urandom));
            end
        end

        // fill the table, then overflow it
        while (tracker.count < NVERT) load_vertex(16'($urandom), 16'($urandom), 16'($urandom));
        repeat (3) load_vertex(16'($urandom), 16'($urandom), 16'($urandom));
        add_tri(11'd1024, 11'd1023, 11'd512);
        read_normal(11'd1024);
        read_normal(11'd1025);
        add_tri(11'd1, 11'd1025, 11'd2);

        wait_drained();
        repeat (200) @(posedge i_clk);
        if (tracker.errors == 0 && tracker.pending_normals.size() == 0)
            $display("vertex_normal_accumulator verification clean");
        else
            $display("vertex_normal_accumulator verification failed");
        $finish;
    end

endmodule
